/* hw/rtl/swbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbl_pkg
// Shared constants and types for the single-wire backlight encoder.
// ----------------------------------------------------------------------------
package swbl_pkg;

  localparam int BITS_PER_BYTE    = 8;
  localparam int POWER_UP_WAIT_US = 200000;

  localparam int LEVEL_W   = 8;
  localparam int DUR_W     = 18;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_CNT_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS = 3'd0,
    REG_SHORT_TIME     = 3'd1,
    REG_LONG_TIME      = 3'd2,
    REG_START_EOS_TIME = 3'd3,
    REG_DETECT_DELAY   = 3'd4,
    REG_DETECT_LOW     = 3'd5,
    REG_DETECT_WINDOW  = 3'd6,
    REG_SHUTDOWN_TIME  = 3'd7
  } reg_idx_t;

  localparam logic [LEVEL_W-1:0] RST_DEVICE_ADDRESS = 8'h72;
  localparam logic [CFG_W-1:0]   RST_SHORT_TIME     = 16'd4;
  localparam logic [CFG_W-1:0]   RST_LONG_TIME      = 16'd8;
  localparam logic [CFG_W-1:0]   RST_START_EOS_TIME = 16'd4;
  localparam logic [CFG_W-1:0]   RST_DETECT_DELAY   = 16'd200;
  localparam logic [CFG_W-1:0]   RST_DETECT_LOW     = 16'd500;
  localparam logic [CFG_W-1:0]   RST_DETECT_WINDOW  = 16'd1000;
  localparam logic [CFG_W-1:0]   RST_SHUTDOWN_TIME  = 16'd5000;

  typedef struct packed {
    logic               load;
    logic               step;
    logic [LEVEL_W-1:0] value;
  } bs_ctrl_t;

  typedef struct packed {
    logic bit_val;
    logic phase;
    logic last;
  } bs_stat_t;

endpackage

/* hw/rtl/swbl_bitser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbl_bitser
// Byte shift register, MSB first, two half-cell phases per bit.
// ----------------------------------------------------------------------------
module swbl_bitser (
  input  logic            clk,
  input  logic            rst,
  input  swbl_pkg::bs_ctrl_t ctrl,
  output swbl_pkg::bs_stat_t stat
);
  import swbl_pkg::*;

  logic [BITS_PER_BYTE-1:0] data;
  logic [BIT_CNT_W-1:0]     cnt;
  logic                     phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      phase <= 1'b0;
    end else if (ctrl.load) begin
      cnt   <= '0;
      phase <= 1'b0;
    end else if (ctrl.step) begin
      phase <= ~phase;
      if (phase) begin
        cnt <= cnt + BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= BITS_PER_BYTE'(ctrl.value);
    end else if (ctrl.step && phase) begin
      data <= data << 1;
    end
  end

  assign stat.bit_val = data[BITS_PER_BYTE-1];
  assign stat.phase   = phase;
  assign stat.last    = phase && (cnt == BIT_CNT_W'(BITS_PER_BYTE - 1));

endmodule

/* hw/rtl/single_wire_backlight_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_backlight_encoder
// Turns a backlight level request into timed pin segments, one beat each.
// First segment: the accepted request sets the sequencer state, from which the first beat is registered.
// Throughput: one segment per cycle while not stalled; a request yields 1 to 41
//   segments, the bit halves among them taken from the byte shift register.
// Next request is taken once the last segment of the current one is loaded.
// Reset: registers to defaults, driver disabled, previous level zero.
// ----------------------------------------------------------------------------
module single_wire_backlight_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [swbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swbl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swbl_pkg::LEVEL_W-1:0]  level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ctrl_pin,
  output logic                          enable_pin,
  output logic [swbl_pkg::DUR_W-1:0]    duration_us,
  output logic                          last_segment
);
  import swbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PWR, S_SHUT, S_DET_HI, S_DET_LO, S_DET_WIN, S_START_A, S_ADDR,
    S_EOS_A, S_START_L, S_LEVEL, S_EOS_L, S_IDLE_HI
  } state_t;

  state_t state;

  logic [LEVEL_W-1:0] device_address;
  logic [CFG_W-1:0]   short_time_us, long_time_us, start_eos_time_us;
  logic [CFG_W-1:0]   detect_delay_us, detect_low_us, detect_window_us;
  logic [CFG_W-1:0]   shutdown_time_us;

  logic               enabled;
  logic [LEVEL_W-1:0] previous_level;
  logic [LEVEL_W-1:0] level_q;

  bs_ctrl_t bs_ctrl;
  bs_stat_t bs_stat;

  logic   in_acc, adv;
  state_t body_first;
  logic   bit_short;

  function automatic state_t first_body(input logic [LEVEL_W-1:0] lvl,
                                        input logic en);
    state_t s;
    if (lvl == '0) s = S_SHUT;
    else if (!en) s = S_DET_HI;
    else s = S_START_A;
    return s;
  endfunction

  assign in_stall   = (state != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign adv        = (state != S_IDLE) && (!out_valid || !out_stall);
  assign body_first = first_body(level_q, enabled);
  assign bit_short  = bs_stat.bit_val ^ bs_stat.phase;

  always_comb begin
    bs_ctrl.load  = adv && (state == S_START_A || state == S_START_L);
    bs_ctrl.step  = adv && (state == S_ADDR || state == S_LEVEL);
    bs_ctrl.value = (state == S_START_A) ? device_address : level_q;
  end

  swbl_bitser u_bitser (
    .clk  (clk),
    .rst  (rst),
    .ctrl (bs_ctrl),
    .stat (bs_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= RST_DEVICE_ADDRESS;
      short_time_us     <= RST_SHORT_TIME;
      long_time_us      <= RST_LONG_TIME;
      start_eos_time_us <= RST_START_EOS_TIME;
      detect_delay_us   <= RST_DETECT_DELAY;
      detect_low_us     <= RST_DETECT_LOW;
      detect_window_us  <= RST_DETECT_WINDOW;
      shutdown_time_us  <= RST_SHUTDOWN_TIME;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_index))
        REG_DEVICE_ADDRESS: device_address    <= cfg_data[LEVEL_W-1:0];
        REG_SHORT_TIME:     short_time_us     <= cfg_data;
        REG_LONG_TIME:      long_time_us      <= cfg_data;
        REG_START_EOS_TIME: start_eos_time_us <= cfg_data;
        REG_DETECT_DELAY:   detect_delay_us   <= cfg_data;
        REG_DETECT_LOW:     detect_low_us     <= cfg_data;
        REG_DETECT_WINDOW:  detect_window_us  <= cfg_data;
        REG_SHUTDOWN_TIME:  shutdown_time_us  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      enabled        <= 1'b0;
      previous_level <= '0;
    end else begin
      if (in_acc) begin
        level_q        <= level;
        previous_level <= level;
        state          <= (previous_level == '0) ? S_PWR : first_body(level, enabled);
      end
      if (adv) begin
        out_valid <= 1'b1;
        case (state)
          S_PWR: begin
            ctrl_pin     <= 1'b0;
            enable_pin   <= 1'b0;
            duration_us  <= DUR_W'(POWER_UP_WAIT_US);
            last_segment <= 1'b0;
            state        <= body_first;
          end
          S_SHUT: begin
            ctrl_pin     <= 1'b0;
            enable_pin   <= 1'b0;
            duration_us  <= DUR_W'(shutdown_time_us);
            last_segment <= 1'b1;
            enabled      <= 1'b0;
            state        <= S_IDLE;
          end
          S_DET_HI: begin
            ctrl_pin     <= 1'b1;
            enable_pin   <= 1'b1;
            duration_us  <= DUR_W'(detect_delay_us);
            last_segment <= 1'b0;
            state        <= S_DET_LO;
          end
          S_DET_LO: begin
            ctrl_pin     <= 1'b0;
            enable_pin   <= 1'b1;
            duration_us  <= DUR_W'(detect_low_us);
            last_segment <= 1'b0;
            state        <= S_DET_WIN;
          end
          S_DET_WIN: begin
            ctrl_pin     <= 1'b1;
            enable_pin   <= 1'b1;
            duration_us  <= DUR_W'(detect_window_us);
            last_segment <= 1'b0;
            state        <= S_START_A;
          end
          S_START_A, S_START_L: begin
            ctrl_pin     <= 1'b1;
            enable_pin   <= 1'b1;
            duration_us  <= DUR_W'(start_eos_time_us);
            last_segment <= 1'b0;
            state        <= (state == S_START_A) ? S_ADDR : S_LEVEL;
          end
          S_ADDR, S_LEVEL: begin
            ctrl_pin     <= bs_stat.phase;
            enable_pin   <= 1'b1;
            duration_us  <= bit_short ? DUR_W'(short_time_us) : DUR_W'(long_time_us);
            last_segment <= 1'b0;
            if (bs_stat.last) begin
              state <= (state == S_ADDR) ? S_EOS_A : S_EOS_L;
            end
          end
          S_EOS_A, S_EOS_L: begin
            ctrl_pin     <= 1'b0;
            enable_pin   <= 1'b1;
            duration_us  <= DUR_W'(start_eos_time_us);
            last_segment <= 1'b0;
            state        <= (state == S_EOS_A) ? S_START_L : S_IDLE_HI;
          end
          S_IDLE_HI: begin
            ctrl_pin     <= 1'b1;
            enable_pin   <= 1'b1;
            duration_us  <= '0;
            last_segment <= 1'b1;
            enabled      <= 1'b1;
            state        <= S_IDLE;
          end
          default: begin
            ctrl_pin     <= 1'b0;
            enable_pin   <= 1'b0;
            duration_us  <= '0;
            last_segment <= 1'b0;
            state        <= S_IDLE;
          end
        endcase
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    adv |=> (last_segment == (state == S_IDLE)))
    else $error("last flag out of step with sequencer");

  a_last_pins_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_segment |-> ctrl_pin == enable_pin)
    else $error("final segment pins disagree");

  a_idle_hi_enables: assert property (@(posedge clk) disable iff (rst)
    adv && state == S_IDLE_HI |=> enabled)
    else $error("driver not marked enabled after level beat");

  a_byte_starts_fresh: assert property (@(posedge clk) disable iff (rst)
    adv && (state == S_START_A || state == S_START_L) |=> !bs_stat.phase)
    else $error("shifter not reset at byte start");

endmodule

/* tb/tb_single_wire_backlight_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_backlight_encoder
// Self-checking bench for the single-wire backlight encoder. A directed table
// covers shutdown, power-up wait, detect sequence and byte extremes under
// reset, maximum, minimum and zero timings. Random requests follow under
// random register settings, with idle and stall on both sides and one long
// output hold-off. Every segment beat is checked against the table or a local predictor.
// ----------------------------------------------------------------------------
module tb_single_wire_backlight_encoder;
  import swbl_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_PER_PHASE = 36;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic             ctrl;
    logic             en;
    logic [DUR_W-1:0] dur;
    logic             last;
  } seg_t;

  typedef struct packed {
    logic [1:0]   phase;
    logic [7:0]   lv;
    logic         typed;
    logic [1:0]   n;
    seg_t         s0;
    seg_t         s1;
  } row_t;

  typedef struct packed {
    logic [CFG_W-1:0] addr;
    logic [CFG_W-1:0] short_t;
    logic [CFG_W-1:0] long_t;
    logic [CFG_W-1:0] start_eos;
    logic [CFG_W-1:0] det_delay;
    logic [CFG_W-1:0] det_low;
    logic [CFG_W-1:0] det_window;
    logic [CFG_W-1:0] shutdown;
  } cfg_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   level = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 ctrl_pin;
  logic                 enable_pin;
  logic [DUR_W-1:0]     duration_us;
  logic                 last_segment;

  single_wire_backlight_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .level        (level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ctrl_pin     (ctrl_pin),
    .enable_pin   (enable_pin),
    .duration_us  (duration_us),
    .last_segment (last_segment)
  );

  // encoder state and register copy
  logic [7:0]       m_addr      = RST_DEVICE_ADDRESS;
  logic [CFG_W-1:0] m_short     = RST_SHORT_TIME;
  logic [CFG_W-1:0] m_long      = RST_LONG_TIME;
  logic [CFG_W-1:0] m_start_eos = RST_START_EOS_TIME;
  logic [CFG_W-1:0] m_det_delay = RST_DETECT_DELAY;
  logic [CFG_W-1:0] m_det_low   = RST_DETECT_LOW;
  logic [CFG_W-1:0] m_det_win   = RST_DETECT_WINDOW;
  logic [CFG_W-1:0] m_shutdown  = RST_SHUTDOWN_TIME;
  logic             m_enabled   = 1'b0;
  logic [7:0]       m_prev_lv   = '0;

  seg_t pending_segs [$];
  seg_t request_segs [$];
  row_t stim_rows [$];

  int   errors       = 0;
  int   segs_checked = 0;
  int   reqs_sent    = 0;
  int   cfg_sets     = 0;
  int   cycles       = 0;
  int   src_idle_pct = 35;
  int   snk_idle_pct = 50;
  int   hold_left    = 0;
  bit   hold_go      = 1'b0;
  seg_t got;
  seg_t want;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run aborted: cycle limit of %0d reached, %0d segments still owed",
               CYCLE_LIMIT, pending_segs.size());
      $display("** single_wire_backlight_encoder: FAILED **");
      $finish;
    end
  end

  function automatic seg_t mk_seg(input logic c, input logic e,
                                  input logic [DUR_W-1:0] d, input logic l);
    seg_t s;
    s.ctrl = c;
    s.en   = e;
    s.dur  = d;
    s.last = l;
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function automatic void set_model_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    case (idx)
      REG_DEVICE_ADDRESS: m_addr      = v[7:0];
      REG_SHORT_TIME:     m_short     = v;
      REG_LONG_TIME:      m_long      = v;
      REG_START_EOS_TIME: m_start_eos = v;
      REG_DETECT_DELAY:   m_det_delay = v;
      REG_DETECT_LOW:     m_det_low   = v;
      REG_DETECT_WINDOW:  m_det_win   = v;
      REG_SHUTDOWN_TIME:  m_shutdown  = v;
      default: ;
    endcase
  endfunction

  function automatic void encode_byte(input logic [7:0] value);
    logic [15:0] wide;
    wide = {8'h00, value};
    for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
      if (wide[i]) begin
        request_segs.push_back(mk_seg(1'b0, 1'b1, DUR_W'(m_short), 1'b0));
        request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_long), 1'b0));
      end else begin
        request_segs.push_back(mk_seg(1'b0, 1'b1, DUR_W'(m_long), 1'b0));
        request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_short), 1'b0));
      end
    end
  endfunction

  function automatic void predict_request(input logic [7:0] lv);
    request_segs.delete();
    if (m_prev_lv == '0)
      request_segs.push_back(mk_seg(1'b0, 1'b0, DUR_W'(POWER_UP_WAIT_US), 1'b0));
    if (lv == '0) begin
      request_segs.push_back(mk_seg(1'b0, 1'b0, DUR_W'(m_shutdown), 1'b1));
      m_enabled = 1'b0;
    end else begin
      if (!m_enabled) begin
        request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_det_delay), 1'b0));
        request_segs.push_back(mk_seg(1'b0, 1'b1, DUR_W'(m_det_low), 1'b0));
        request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_det_win), 1'b0));
      end
      request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_start_eos), 1'b0));
      encode_byte(m_addr);
      request_segs.push_back(mk_seg(1'b0, 1'b1, DUR_W'(m_start_eos), 1'b0));
      request_segs.push_back(mk_seg(1'b1, 1'b1, DUR_W'(m_start_eos), 1'b0));
      encode_byte(lv);
      request_segs.push_back(mk_seg(1'b0, 1'b1, DUR_W'(m_start_eos), 1'b0));
      request_segs.push_back(mk_seg(1'b1, 1'b1, '0, 1'b1));
      m_enabled = 1'b1;
    end
    m_prev_lv = lv;
  endfunction

  function automatic void add_row(input logic [1:0] ph, input logic [7:0] lv,
                                  input logic typed, input logic [1:0] n,
                                  input seg_t s0, input seg_t s1);
    row_t r;
    r.phase = ph;
    r.lv    = lv;
    r.typed = typed;
    r.n     = n;
    r.s0    = s0;
    r.s1    = s1;
    stim_rows.push_back(r);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.addr       = CFG_W'($urandom_range(65535));
    c.short_t    = CFG_W'($urandom_range(65535, 1));
    c.long_t     = CFG_W'($urandom_range(65535, 1));
    c.start_eos  = CFG_W'($urandom_range(65535, 1));
    c.det_delay  = CFG_W'($urandom_range(65535, 1));
    c.det_low    = CFG_W'($urandom_range(65535, 1));
    c.det_window = CFG_W'($urandom_range(65535, 1));
    c.shutdown   = CFG_W'($urandom_range(65535, 1));
    return c;
  endfunction

  // one beat per request; expectations are queued at the accepting edge
  task automatic send_row(input row_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level    <= r.lv;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_request(r.lv);
    if (r.typed) begin
      pending_segs.push_back(r.s0);
      if (r.n == 2'd2) pending_segs.push_back(r.s1);
    end else begin
      foreach (request_segs[i]) pending_segs.push_back(request_segs[i]);
    end
    reqs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    reg_idx_t         idx [8];
    logic [CFG_W-1:0] val [8];
    idx = '{REG_DEVICE_ADDRESS, REG_SHORT_TIME, REG_LONG_TIME, REG_START_EOS_TIME,
            REG_DETECT_DELAY, REG_DETECT_LOW, REG_DETECT_WINDOW, REG_SHUTDOWN_TIME};
    val = '{c.addr, c.short_t, c.long_t, c.start_eos,
            c.det_delay, c.det_low, c.det_window, c.shutdown};
    for (int k = 0; k < 8; k++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      set_model_reg(idx[k], val[k]);
    end
    cfg_wen <= 1'b0;
    cfg_sets++;
  endtask

  // output side: check accepted beats, then pick next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = mk_seg(ctrl_pin, enable_pin, duration_us, last_segment);
        if (pending_segs.size() == 0) begin
          report_mismatch($sformatf("unexpected segment ctrl=%0b en=%0b dur=%0d last=%0b",
                                    got.ctrl, got.en, got.dur, got.last));
        end else begin
          want = pending_segs.pop_front();
          if (got.ctrl !== want.ctrl)
            report_mismatch($sformatf("seg %0d ctrl_pin %0b, want %0b",
                                      segs_checked, got.ctrl, want.ctrl));
          if (got.en !== want.en)
            report_mismatch($sformatf("seg %0d enable_pin %0b, want %0b",
                                      segs_checked, got.en, want.en));
          if (got.dur !== want.dur)
            report_mismatch($sformatf("seg %0d duration_us %0d, want %0d",
                                      segs_checked, got.dur, want.dur));
          if (got.last !== want.last)
            report_mismatch($sformatf("seg %0d last_segment %0b, want %0b",
                                      segs_checked, got.last, want.last));
          segs_checked++;
        end
      end
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < snk_idle_pct);
      end
    end
  end

  initial begin
    cfg_t  dir_cfgs [4];
    cfg_t  c;
    row_t  r;
    logic [1:0] cur_phase;
    seg_t  pu;

    pu = mk_seg(1'b0, 1'b0, DUR_W'(POWER_UP_WAIT_US), 1'b0);
    dir_cfgs[0] = '{16'h0072, 16'd4, 16'd8, 16'd4, 16'd200, 16'd500, 16'd1000, 16'd5000};
    dir_cfgs[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    dir_cfgs[2] = '{16'h0000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    dir_cfgs[3] = '{16'hA5C3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};

    // reset timings
    add_row(2'd0, 8'h00, 1'b1, 2'd2, pu, mk_seg(1'b0, 1'b0, 18'd5000, 1'b1));
    add_row(2'd0, 8'h00, 1'b1, 2'd2, pu, mk_seg(1'b0, 1'b0, 18'd5000, 1'b1));
    add_row(2'd0, 8'hFF, 1'b0, 2'd0, '0, '0);
    add_row(2'd0, 8'h01, 1'b0, 2'd0, '0, '0);
    add_row(2'd0, 8'h00, 1'b1, 2'd1, mk_seg(1'b0, 1'b0, 18'd5000, 1'b1), '0);
    add_row(2'd0, 8'h80, 1'b0, 2'd0, '0, '0);
    add_row(2'd0, 8'hAA, 1'b0, 2'd0, '0, '0);
    add_row(2'd0, 8'h55, 1'b0, 2'd0, '0, '0);
    add_row(2'd0, 8'h00, 1'b1, 2'd1, mk_seg(1'b0, 1'b0, 18'd5000, 1'b1), '0);
    add_row(2'd0, 8'h00, 1'b1, 2'd2, pu, mk_seg(1'b0, 1'b0, 18'd5000, 1'b1));
    add_row(2'd0, 8'h7F, 1'b0, 2'd0, '0, '0);
    // maximum timings
    add_row(2'd1, 8'h01, 1'b0, 2'd0, '0, '0);
    add_row(2'd1, 8'hFF, 1'b0, 2'd0, '0, '0);
    add_row(2'd1, 8'h00, 1'b1, 2'd1, mk_seg(1'b0, 1'b0, 18'd65535, 1'b1), '0);
    add_row(2'd1, 8'hFE, 1'b0, 2'd0, '0, '0);
    // minimum timings, address zero
    add_row(2'd2, 8'hFF, 1'b0, 2'd0, '0, '0);
    add_row(2'd2, 8'h00, 1'b1, 2'd1, mk_seg(1'b0, 1'b0, 18'd1, 1'b1), '0);
    add_row(2'd2, 8'h00, 1'b1, 2'd2, pu, mk_seg(1'b0, 1'b0, 18'd1, 1'b1));
    add_row(2'd2, 8'h01, 1'b0, 2'd0, '0, '0);
    // zero timings
    add_row(2'd3, 8'h5A, 1'b0, 2'd0, '0, '0);
    add_row(2'd3, 8'h00, 1'b1, 2'd1, mk_seg(1'b0, 1'b0, 18'd0, 1'b1), '0);
    add_row(2'd3, 8'h00, 1'b1, 2'd2, pu, mk_seg(1'b0, 1'b0, 18'd0, 1'b1));
    add_row(2'd3, 8'hC3, 1'b0, 2'd0, '0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_phase = 2'd0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].phase != cur_phase) begin
        drain();
        apply_cfg(dir_cfgs[stim_rows[i].phase]);
        cur_phase = stim_rows[i].phase;
      end
      send_row(stim_rows[i]);
    end

    // random requests: mostly nonzero so the byte path dominates
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      c = rand_cfg();
      apply_cfg(c);
      src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 50 : 0;
      snk_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 35 : 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 2 && k == 4) hold_go = 1'b1;
        r       = '0;
        r.lv    = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(255, 1));
        r.typed = 1'b0;
        send_row(r);
      end
    end

    drain();
    if (pending_segs.size() != 0)
      report_mismatch($sformatf("%0d segments never arrived", pending_segs.size()));

    $display("Run covered %0d requests and %0d segment beats under %0d register settings.",
             reqs_sent, segs_checked, cfg_sets + 1);
    $display("Shutdown, power-up wait, detect and byte extremes seen; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("** single_wire_backlight_encoder: PASSED **");
    end else begin
      $display("** single_wire_backlight_encoder: FAILED **");
    end
    $finish;
  end

endmodule
